FILE: rtl/kmh_pkg.sv
// Shared types, constants and widths of the k-way merge min-heap.
`timescale 1ns / 1ps
package kmh_pkg;

  localparam int CAPACITY = 64;
  localparam int KEY_BITS = 64;

  localparam int KEY_FW  = 64;
  localparam int RANK_W  = 6;
  localparam int SLOT_W  = 6;
  localparam int STAT_W  = 2;
  localparam int OCC_W   = 7;

  localparam int IDX_W   = $clog2(CAPACITY);
  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int CHW     = IDX_W + 2;

  localparam int IN_DATA_BITS  = KEY_FW + RANK_W + SLOT_W;
  localparam int IN_TDATA_W    = ((IN_DATA_BITS + 7) / 8) * 8;
  localparam int IN_RANK_LSB   = KEY_FW;
  localparam int IN_SLOT_LSB   = KEY_FW + RANK_W;

  localparam int OUT_DATA_BITS = SLOT_W + KEY_FW + RANK_W + OCC_W;
  localparam int OUT_TDATA_W   = ((OUT_DATA_BITS + 7) / 8) * 8;
  localparam int OUT_PAD_W     = OUT_TDATA_W - OUT_DATA_BITS;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [RANK_W-1:0]   rank;
    logic [SLOT_W-1:0]   slot;
  } entry_t;

  typedef struct packed {
    op_e    op;
    entry_t ent;
  } item_t;

  typedef struct packed {
    status_e             status;
    logic [KEY_BITS-1:0] key;
    logic [RANK_W-1:0]   rank;
    logic [SLOT_W-1:0]   slot;
    logic [OCC_W-1:0]    occupancy;
  } res_t;

endpackage

FILE: rtl/kmh_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
`timescale 1ns / 1ps
module kmh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re0_i,
  input  logic [$clog2(DEPTH)-1:0] raddr0_i,
  output logic [WIDTH-1:0]         rdata0_o,
  input  logic                     re1_i,
  input  logic [$clog2(DEPTH)-1:0] raddr1_i,
  output logic [WIDTH-1:0]         rdata1_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re0_i) begin
      rdata0_o <= mem[raddr0_i];
    end
    if (re1_i) begin
      rdata1_o <= mem[raddr1_i];
    end
  end

endmodule

FILE: rtl/kmh_cmp.sv
// Heap order compare: key first, then tie rank, lower wins.
`timescale 1ns / 1ps
module kmh_cmp import kmh_pkg::*; (
  input  entry_t a_i,
  input  entry_t b_i,
  output logic   before_o
);

  assign before_o = (a_i.key != b_i.key) ? (a_i.key < b_i.key) : (a_i.rank < b_i.rank);

endmodule

FILE: rtl/kmh_core.sv
// Heap sequencer: sift up and sift down over the entry RAM with one comparator.
`timescale 1ns / 1ps
module kmh_core import kmh_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  item_t item_i,
  output logic  ready_o,
  input  logic  out_free_i,
  output logic  res_valid_o,
  output res_t  res_o
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_UP     = 8'b0000_0010,
    S_UP_CMP = 8'b0000_0100,
    S_POP_RD = 8'b0000_1000,
    S_POP_LD = 8'b0001_0000,
    S_DN_SEL = 8'b0010_0000,
    S_DN_CMP = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_e;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [IDX_W-1:0]  pos_q, pos_d;
  logic [IDX_W-1:0]  cidx_q, cidx_d;
  entry_t            ent_q, ent_d;
  entry_t            child_q, child_d;
  status_e           stat_q, stat_d;
  entry_t            pop_q, pop_d;

  logic              we;
  logic [IDX_W-1:0]  waddr;
  entry_t            wdata;
  logic              re0, re1;
  logic [IDX_W-1:0]  raddr0, raddr1;
  entry_t            rdata0, rdata1;

  entry_t            cmp_a, cmp_b;
  logic              a_first;

  logic [IDX_W-1:0]  par, ppar;
  logic [CHW-1:0]    lidx, ridx, nl, nr, cnt_x;

  kmh_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i    (clk_i),
    .we_i     (we),
    .waddr_i  (waddr),
    .wdata_i  (wdata),
    .re0_i    (re0),
    .raddr0_i (raddr0),
    .rdata0_o (rdata0),
    .re1_i    (re1),
    .raddr1_i (raddr1),
    .rdata1_o (rdata1)
  );

  kmh_cmp u_cmp (
    .a_i      (cmp_a),
    .b_i      (cmp_b),
    .before_o (a_first)
  );

  assign par   = (pos_q - IDX_W'(1)) >> 1;
  assign ppar  = (par - IDX_W'(1)) >> 1;
  assign lidx  = CHW'({pos_q, 1'b1});
  assign ridx  = lidx + CHW'(1);
  assign nl    = CHW'({cidx_q, 1'b1});
  assign nr    = nl + CHW'(1);
  assign cnt_x = CHW'(count_q);

  always_comb begin
    case (state_q)
      S_UP_CMP: begin
        cmp_a = ent_q;
        cmp_b = rdata0;
      end
      S_DN_SEL: begin
        cmp_a = rdata1;
        cmp_b = rdata0;
      end
      S_DN_CMP: begin
        cmp_a = child_q;
        cmp_b = ent_q;
      end
      default: begin
        cmp_a = ent_q;
        cmp_b = rdata0;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    pos_d   = pos_q;
    cidx_d  = cidx_q;
    ent_d   = ent_q;
    child_d = child_q;
    stat_d  = stat_q;
    pop_d   = pop_q;
    we      = 1'b0;
    waddr   = pos_q;
    wdata   = ent_q;
    re0     = 1'b0;
    re1     = 1'b0;
    raddr0  = par;
    raddr1  = par;
    res_valid_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          stat_d = ST_OK;
          pop_d  = '0;
          if (item_i.op == OP_PUSH) begin
            if (count_q == CNT_W'(CAPACITY)) begin
              stat_d  = ST_FULL;
              state_d = S_DONE;
            end else begin
              ent_d   = item_i.ent;
              pos_d   = IDX_W'(count_q);
              count_d = count_q + CNT_W'(1);
              state_d = S_UP;
            end
          end else begin
            if (count_q == '0) begin
              stat_d  = ST_EMPTY;
              state_d = S_DONE;
            end else begin
              state_d = S_POP_RD;
            end
          end
        end
      end
      S_UP: begin
        if (pos_q == '0) begin
          we      = 1'b1;
          state_d = S_DONE;
        end else begin
          re0     = 1'b1;
          state_d = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        we = 1'b1;
        if (a_first) begin
          wdata = rdata0;
          pos_d = par;
          if (par == '0) begin
            state_d = S_UP;
          end else begin
            re0    = 1'b1;
            raddr0 = ppar;
          end
        end else begin
          state_d = S_DONE;
        end
      end
      S_POP_RD: begin
        re0     = 1'b1;
        re1     = 1'b1;
        raddr0  = '0;
        raddr1  = IDX_W'(count_q - CNT_W'(1));
        count_d = count_q - CNT_W'(1);
        state_d = S_POP_LD;
      end
      S_POP_LD: begin
        pop_d = rdata0;
        if (count_q == '0) begin
          state_d = S_DONE;
        end else begin
          ent_d   = rdata1;
          pos_d   = '0;
          re0     = 1'b1;
          re1     = 1'b1;
          raddr0  = IDX_W'(1);
          raddr1  = IDX_W'(2);
          state_d = S_DN_SEL;
        end
      end
      S_DN_SEL: begin
        if (lidx >= cnt_x) begin
          we      = 1'b1;
          state_d = S_DONE;
        end else begin
          if (ridx < cnt_x && a_first) begin
            child_d = rdata1;
            cidx_d  = ridx[IDX_W-1:0];
          end else begin
            child_d = rdata0;
            cidx_d  = lidx[IDX_W-1:0];
          end
          state_d = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        we = 1'b1;
        if (a_first) begin
          wdata   = child_q;
          pos_d   = cidx_q;
          re0     = 1'b1;
          re1     = 1'b1;
          raddr0  = nl[IDX_W-1:0];
          raddr1  = nr[IDX_W-1:0];
          state_d = S_DN_SEL;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free_i) begin
          res_valid_o = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q   <= pos_d;
    cidx_q  <= cidx_d;
    ent_q   <= ent_d;
    child_q <= child_d;
    stat_q  <= stat_d;
    pop_q   <= pop_d;
  end

  assign ready_o = (state_q == S_IDLE);

  assign res_o.status    = stat_q;
  assign res_o.key       = pop_q.key;
  assign res_o.rank      = pop_q.rank;
  assign res_o.slot      = pop_q.slot;
  assign res_o.occupancy = OCC_W'(count_q);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("heap count beyond capacity");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (state_q != S_IDLE && state_q != S_DONE))
    else $error("entry write outside a sift");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.status == ST_FULL |-> count_q == CNT_W'(CAPACITY))
    else $error("full status with room left");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.status == ST_EMPTY |-> count_q == '0)
    else $error("empty status on a filled heap");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DN_CMP |-> (CHW'(cidx_q) < cnt_x && cidx_q > pos_q))
    else $error("sift down child out of range");

endmodule

FILE: rtl/kway_merge_min_heap.sv
// Top level of the k-way merge min-heap: stream ports and result register.
//
// Usage: each input beat on s_axis is one operation. s_axis_tuser selects
// push (0) or pop (1); a push stores key, tie rank and slot in the heap.
// Every beat gives exactly one result beat on m_axis: the popped entry
// (zero for a push), the occupancy after the operation and a status in
// m_axis_tuser (0 ok, 1 pop on empty heap, 2 push on full heap).
// Steps: a push reads the parent and compares, moving the parent down, for
// each level climbed, then writes the new entry when a compare stops or the
// root is reached; a pop reads the root and the last entry, then per level
// selects the lesser child and compares it with the moved entry until a
// compare stops the walk or no child is left; a pop on an empty heap or a
// push on a full one goes straight to the result. The single comparator
// and the registered RAM read shape each step. s_axis_tready is high only
// between operations, so the next beat is taken once the result is registered.
// The result waits in an output register, so the next beat is taken while
// m_axis stalls; a finished operation then waits until that register frees.
// Reset empties the heap at once; no clearing pass is run.
`timescale 1ns / 1ps
module kway_merge_min_heap import kmh_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // key[63:0], tie_rank[69:64], slot[75:70], zero pad
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // op
  input  logic                   s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // out_slot[5:0], out_key[69:6], out_rank[75:70], occupancy[82:76], zero pad
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // status
  output logic [STAT_W-1:0]      m_axis_tuser
);

  item_t item;
  logic  core_ready;
  logic  start;
  logic  out_free;
  logic  res_valid;
  res_t  res;
  logic  out_valid_q, out_valid_d;
  res_t  out_q;

  assign item.op       = op_e'(s_axis_tuser);
  assign item.ent.key  = s_axis_tdata[KEY_BITS-1:0];
  assign item.ent.rank = s_axis_tdata[IN_RANK_LSB +: RANK_W];
  assign item.ent.slot = s_axis_tdata[IN_SLOT_LSB +: SLOT_W];

  assign s_axis_tready = core_ready;
  assign start         = s_axis_tvalid && core_ready;
  assign out_free      = !out_valid_q || m_axis_tready;

  kmh_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .item_i      (item),
    .ready_o     (core_ready),
    .out_free_i  (out_free),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_q.occupancy, out_q.rank,
                          KEY_FW'(out_q.key), out_q.slot};

endmodule
